// File: hdl/e2q_pkg.sv
// Shared constants and types for the Euler angle to unit quaternion converter.
// No dependencies.
package e2q_pkg;

    localparam int FIELD_W            = 16;
    localparam int ANGLE_BITS_DEF     = 16;
    localparam int QUAT_FRAC_BITS_DEF = 14;

    localparam int ROT_STEPS = 30;
    localparam int TRIG_W    = 33;   // Q30 sine/cosine with headroom
    localparam int PHASE_W   = 34;   // residual angle, 2^32 per turn
    localparam int QUAT_W    = 34;   // unnormalised component, Q30
    localparam int SUMSQ_W   = 64;
    localparam int NORM_W    = 32;
    localparam int ISQRT_STEPS = SUMSQ_W / 2;

    localparam logic signed [TRIG_W-1:0] GAIN_Q30 = 33'sh026DD3B6A;

    localparam logic [31:0] STEP_ANGLE [ROT_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    typedef struct packed {
        logic signed [QUAT_W-1:0] w;
        logic signed [QUAT_W-1:0] x;
        logic signed [QUAT_W-1:0] y;
        logic signed [QUAT_W-1:0] z;
    } t_quat;

endpackage

// File: hdl/e2q_if.sv
// Valid/ready channel interfaces for angle items and quaternion items.
// Depends on e2q_pkg.
interface e2q_angle_if;
    import e2q_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [FIELD_W-1:0]  angle_first;
    logic signed [FIELD_W-1:0]  angle_second;
    logic signed [FIELD_W-1:0]  angle_third;
    modport source (output valid, angle_first, angle_second, angle_third, input ready);
    modport sink   (input valid, angle_first, angle_second, angle_third, output ready);
endinterface

interface e2q_quat_if;
    import e2q_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [FIELD_W-1:0]  quat_w;
    logic signed [FIELD_W-1:0]  quat_x;
    logic signed [FIELD_W-1:0]  quat_y;
    logic signed [FIELD_W-1:0]  quat_z;
    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// File: hdl/e2q_cordic.sv
// Three-lane pipelined rotation CORDIC, one step per stage, for the half angles.
// Depends on e2q_pkg.
module e2q_cordic #(
    parameter int ANGLE_BITS = e2q_pkg::ANGLE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic [e2q_pkg::FIELD_W-1:0]          i_ang_a0,
    input  logic [e2q_pkg::FIELD_W-1:0]          i_ang_a1,
    input  logic [e2q_pkg::FIELD_W-1:0]          i_ang_a2,
    output logic                                 o_valid,
    output logic signed [e2q_pkg::TRIG_W-1:0]    o_sin [3],
    output logic signed [e2q_pkg::TRIG_W-1:0]    o_cos [3]
);
    import e2q_pkg::*;

    localparam int PAD = 33 - ANGLE_BITS;

    logic signed [TRIG_W-1:0]  s_x [ROT_STEPS+1][3];
    logic signed [TRIG_W-1:0]  s_y [ROT_STEPS+1][3];
    logic signed [PHASE_W-1:0] s_z [ROT_STEPS+1][3];
    logic                      r_v [ROT_STEPS+1];

    logic [31:0]        raw [3];
    logic signed [32:0] ph  [3];

    assign raw[0] = 32'(i_ang_a0);
    assign raw[1] = 32'(i_ang_a1);
    assign raw[2] = 32'(i_ang_a2);

    // sign-extend from ANGLE_BITS-1 and scale to 2^32 per turn, halved (floor)
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            ph[l] = $signed({raw[l][ANGLE_BITS-1:0], {PAD{1'b0}}}) >>> 2;
        end
        s_z[0][0] = PHASE_W'(ph[0]);
        s_z[0][1] = -PHASE_W'(ph[1]);
        s_z[0][2] = PHASE_W'(ph[2]);
        for (int l = 0; l < 3; l++) begin
            s_x[0][l] = GAIN_Q30;
            s_y[0][l] = '0;
        end
    end
    assign r_v[0] = i_valid;

    for (genvar i = 0; i < ROT_STEPS; i++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_en) begin
                r_v[i+1] <= r_v[i];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int l = 0; l < 3; l++) begin
                    if (!s_z[i][l][PHASE_W-1]) begin
                        s_x[i+1][l] <= s_x[i][l] - (s_y[i][l] >>> i);
                        s_y[i+1][l] <= s_y[i][l] + (s_x[i][l] >>> i);
                        s_z[i+1][l] <= s_z[i][l] - PHASE_W'(STEP_ANGLE[i]);
                    end else begin
                        s_x[i+1][l] <= s_x[i][l] + (s_y[i][l] >>> i);
                        s_y[i+1][l] <= s_y[i][l] - (s_x[i][l] >>> i);
                        s_z[i+1][l] <= s_z[i][l] + PHASE_W'(STEP_ANGLE[i]);
                    end
                end
            end
        end
    end

    assign o_valid = r_v[ROT_STEPS];
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            o_sin[l] = s_y[ROT_STEPS][l];
            o_cos[l] = s_x[ROT_STEPS][l];
        end
    end

endmodule

// File: hdl/e2q_isqrt.sv
// Pipelined 64-bit integer square root, one result bit per stage; carries the
// quaternion along. Depends on e2q_pkg.
module e2q_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [e2q_pkg::SUMSQ_W-1:0]   i_sumsq,
    input  e2q_pkg::t_quat                i_quat,
    output logic                          o_valid,
    output logic [e2q_pkg::NORM_W-1:0]    o_norm,
    output e2q_pkg::t_quat                o_quat
);
    import e2q_pkg::*;

    logic [SUMSQ_W-1:0] s_v [ISQRT_STEPS+1];
    logic [SUMSQ_W-1:0] s_r [ISQRT_STEPS+1];
    t_quat              s_q [ISQRT_STEPS+1];
    logic               r_vl [ISQRT_STEPS+1];

    assign s_v[0]  = i_sumsq;
    assign s_r[0]  = '0;
    assign s_q[0]  = i_quat;
    assign r_vl[0] = i_valid;

    for (genvar k = 0; k < ISQRT_STEPS; k++) begin : g_bit
        localparam logic [SUMSQ_W-1:0] BIT = SUMSQ_W'(1) << (SUMSQ_W - 2 - 2 * k);
        logic [SUMSQ_W-1:0] trial;
        assign trial = s_r[k] + BIT;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vl[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vl[k+1] <= r_vl[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                s_q[k+1] <= s_q[k];
                if (s_v[k] >= trial) begin
                    s_v[k+1] <= s_v[k] - trial;
                    s_r[k+1] <= (s_r[k] >> 1) + BIT;
                end else begin
                    s_v[k+1] <= s_v[k];
                    s_r[k+1] <= s_r[k] >> 1;
                end
            end
        end
    end

    assign o_valid = r_vl[ISQRT_STEPS];
    assign o_norm  = s_r[ISQRT_STEPS][NORM_W-1:0];
    assign o_quat  = s_q[ISQRT_STEPS];

endmodule

// File: hdl/e2q_div.sv
// Four-lane pipelined restoring divider: rounded |q| * 2^F / norm, saturated,
// signed, with the output register. Depends on e2q_pkg.
module e2q_div #(
    parameter int QUAT_FRAC_BITS = e2q_pkg::QUAT_FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic [e2q_pkg::NORM_W-1:0]         i_norm,
    input  e2q_pkg::t_quat                     i_quat,
    output logic                               o_valid,
    output logic signed [e2q_pkg::FIELD_W-1:0] o_res [4]
);
    import e2q_pkg::*;

    localparam int QB = QUAT_FRAC_BITS + 2;            // quotient bits
    localparam int NW = QUAT_W + QUAT_FRAC_BITS + 1;   // remainder width
    localparam logic [QB-1:0] ONE = QB'(1) << QUAT_FRAC_BITS;

    logic signed [QUAT_W-1:0] comp [4];
    logic [NW-1:0]     s_rem [QB+1][4];
    logic [QB-1:0]     s_quo [QB+1][4];
    logic [3:0]        s_neg [QB+1];
    logic [NORM_W-1:0] s_nrm [QB+1];
    logic              s_zero[QB+1];
    logic              r_vl  [QB+2];
    logic [QB-1:0]     sat   [4];
    logic [QB+FIELD_W-1:0] mag_ext [4];
    logic [QB+FIELD_W-1:0] sgn_ext [4];

    assign comp[0] = i_quat.w;
    assign comp[1] = i_quat.x;
    assign comp[2] = i_quat.y;
    assign comp[3] = i_quat.z;

    // one valid bit per register stage: entry, QB quotient stages, output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < QB + 2; s++) r_vl[s] <= 1'b0;
        end else if (i_en) begin
            r_vl[0] <= i_valid;
            for (int s = 1; s < QB + 2; s++) r_vl[s] <= r_vl[s-1];
        end
    end

    // numerator with the half-divisor rounding term
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 4; l++) begin
                s_neg[0][l] <= comp[l][QUAT_W-1];
                s_rem[0][l] <= (NW'(comp[l][QUAT_W-1] ? -comp[l] : comp[l])
                                << QUAT_FRAC_BITS) + NW'(i_norm >> 1);
                s_quo[0][l] <= '0;
            end
            s_nrm[0]  <= i_norm;
            s_zero[0] <= (i_norm == '0);
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_qbit
        localparam int SH = QB - 1 - k;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int l = 0; l < 4; l++) begin
                    if (s_rem[k][l] >= (NW'(s_nrm[k]) << SH)) begin
                        s_rem[k+1][l] <= s_rem[k][l] - (NW'(s_nrm[k]) << SH);
                        s_quo[k+1][l] <= s_quo[k][l] | (QB'(1) << SH);
                    end else begin
                        s_rem[k+1][l] <= s_rem[k][l];
                        s_quo[k+1][l] <= s_quo[k][l];
                    end
                end
                s_neg[k+1]  <= s_neg[k];
                s_nrm[k+1]  <= s_nrm[k];
                s_zero[k+1] <= s_zero[k];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            sat[l]     = (s_quo[QB][l] > ONE) ? ONE : s_quo[QB][l];
            mag_ext[l] = s_zero[QB] ? '0 : (QB+FIELD_W)'(sat[l]);
            sgn_ext[l] = s_neg[QB][l] ? -mag_ext[l] : mag_ext[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 4; l++) o_res[l] <= $signed(sgn_ext[l][FIELD_W-1:0]);
        end
    end

    assign o_valid = r_vl[QB+1];

endmodule

// File: hdl/euler_to_unit_quaternion_top.sv
// Euler angle to unit quaternion converter: top level with the product,
// sum and square stages. Depends on e2q_pkg, e2q_if, e2q_cordic, e2q_isqrt, e2q_div.
//
// Usage:
//   i_angles carries one item of three signed binary Euler angles (2^ANGLE_BITS
//   units per turn); o_quat returns the normalised quaternion w, x, y, z in
//   signed fixed point with QUAT_FRAC_BITS fraction bits, saturated to +-1.
//   One result item per input item, in order.
//   Throughput: one item per cycle while not stalled. Stages from acceptance
//   to o_quat.valid: 30 CORDIC steps, two product stages, sum, square, sum of
//   squares, 32 root stages, then QUAT_FRAC_BITS + 2 divider stages with
//   their entry and output registers.
//   The whole pipeline advances together; it holds while o_quat.valid is high
//   and o_quat.ready is low, and i_angles.ready is low only then.
//   Reset (synchronous, active low) clears every valid bit; items in flight
//   are dropped. No state is kept between items.
//
module euler_to_unit_quaternion_top #(
    parameter int ANGLE_BITS     = e2q_pkg::ANGLE_BITS_DEF,
    parameter int QUAT_FRAC_BITS = e2q_pkg::QUAT_FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    e2q_angle_if.sink     i_angles,
    e2q_quat_if.source    o_quat
);
    import e2q_pkg::*;

    logic en;
    assign en = !o_quat.valid || o_quat.ready;
    assign i_angles.ready = en;

    logic                     cor_v;
    logic signed [TRIG_W-1:0] sn [3];
    logic signed [TRIG_W-1:0] cs [3];

    e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_angles.valid),
        .i_ang_a0 (i_angles.angle_third),
        .i_ang_a1 (i_angles.angle_second),
        .i_ang_a2 (i_angles.angle_first),
        .o_valid  (cor_v),
        .o_sin    (sn),
        .o_cos    (cs)
    );

    // pair products of lanes 0 and 2
    logic signed [2*TRIG_W-1:0] pm1 [4];
    logic signed [TRIG_W-1:0]   r_pp [4];   // cc, cs, sc, ss
    logic                       r_pp_v;
    assign pm1[0] = cs[0] * cs[2];
    assign pm1[1] = cs[0] * sn[2];
    assign pm1[2] = sn[0] * cs[2];
    assign pm1[3] = sn[0] * sn[2];

    // triple products with lane 1: c1*{cc,cs,sc,ss} and s1*{cc,cs,sc,ss}
    logic signed [TRIG_W-1:0]   r_tp [8];
    logic                       r_tp_v;
    // lane 1 trig has moved on by a stage, so hold a copy aligned with r_pp
    logic signed [TRIG_W-1:0] r_s1, r_c1;
    logic signed [2*TRIG_W-1:0] pm2a [8];
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            pm2a[j]     = r_c1 * r_pp[j];
            pm2a[j + 4] = r_s1 * r_pp[j];
        end
    end

    t_quat r_q;
    logic  r_q_v;
    logic [SUMSQ_W-1:0] r_sq [4];
    t_quat r_sq_q;
    logic  r_sq_v;
    logic [SUMSQ_W-1:0] r_sum;
    t_quat r_sum_q;
    logic  r_sum_v;
    logic signed [2*QUAT_W-1:0] sqm [4];

    assign sqm[0] = r_q.w * r_q.w;
    assign sqm[1] = r_q.x * r_q.x;
    assign sqm[2] = r_q.y * r_q.y;
    assign sqm[3] = r_q.z * r_q.z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp_v  <= 1'b0;
            r_tp_v  <= 1'b0;
            r_q_v   <= 1'b0;
            r_sq_v  <= 1'b0;
            r_sum_v <= 1'b0;
        end else if (en) begin
            r_pp_v  <= cor_v;
            r_tp_v  <= r_pp_v;
            r_q_v   <= r_tp_v;
            r_sq_v  <= r_q_v;
            r_sum_v <= r_sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 4; j++) r_pp[j] <= pm1[j][30 +: TRIG_W];
            r_c1 <= cs[1];
            r_s1 <= sn[1];
            for (int j = 0; j < 8; j++) r_tp[j] <= pm2a[j][30 +: TRIG_W];
            // r_tp: 0 c1cc, 1 c1cs, 2 c1sc, 3 c1ss, 4 s1cc, 5 s1cs, 6 s1sc, 7 s1ss
            r_q.w <= QUAT_W'(r_tp[0]) + QUAT_W'(r_tp[7]);
            r_q.z <= QUAT_W'(r_tp[2]) - QUAT_W'(r_tp[5]);
            r_q.y <= -(QUAT_W'(r_tp[3]) + QUAT_W'(r_tp[4]));
            r_q.x <= QUAT_W'(r_tp[1]) - QUAT_W'(r_tp[6]);
            for (int j = 0; j < 4; j++) r_sq[j] <= sqm[j][SUMSQ_W-1:0];
            r_sq_q  <= r_q;
            r_sum   <= r_sq[0] + r_sq[1] + r_sq[2] + r_sq[3];
            r_sum_q <= r_sq_q;
        end
    end

    logic               rt_v;
    logic [NORM_W-1:0]  rt_norm;
    t_quat              rt_q;

    e2q_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_sum_v),
        .i_sumsq (r_sum),
        .i_quat  (r_sum_q),
        .o_valid (rt_v),
        .o_norm  (rt_norm),
        .o_quat  (rt_q)
    );

    logic signed [FIELD_W-1:0] res [4];

    e2q_div #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (rt_v),
        .i_norm  (rt_norm),
        .i_quat  (rt_q),
        .o_valid (o_quat.valid),
        .o_res   (res)
    );

    assign o_quat.quat_w = res[0];
    assign o_quat.quat_x = res[1];
    assign o_quat.quat_y = res[2];
    assign o_quat.quat_z = res[3];

    // a waiting result item stays put until the receiver takes it
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_quat.valid && !o_quat.ready) |=>
            (o_quat.valid && $stable(o_quat.quat_w) && $stable(o_quat.quat_x)
             && $stable(o_quat.quat_y) && $stable(o_quat.quat_z)))
        else $error("output item changed while waiting");

    a_norm_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sum_v |-> (r_sum != '0))
        else $error("sum of squares is zero for a valid item");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> ($stable(r_sum_v) && $stable(r_q_v) && $stable(r_sum)))
        else $error("pipeline moved during a stall");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_quat.valid)
        else $error("output valid after reset");

endmodule
